// ===== rtl/sorted_window_trimmed_mean_macros.svh =====
// Assertion macros for the sorted window trimmed mean block.
// Used by modules that have clk_i and rst_ni in scope.
`ifndef SORTED_WINDOW_TRIMMED_MEAN_MACROS_SVH
`define SORTED_WINDOW_TRIMMED_MEAN_MACROS_SVH

// Property checked on every rising edge, off while in reset
`define SWTM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Same-cycle implication form
`define SWTM_ASSERT_IMP(lbl, ante, cons, msg) \
  `SWTM_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// ===== rtl/swtm_pkg.sv =====
// Shared constants and types for the sorted window trimmed mean block.
// No dependencies; used by swtm_ctrl, swtm_dp and the top level.
`timescale 1ns / 1ps

package swtm_pkg;

  // store geometry
  localparam int unsigned MaxSamples = 256;
  localparam int unsigned AddrW      = $clog2(MaxSamples);
  localparam int unsigned CntW       = AddrW + 1;

  // field widths
  localparam int unsigned SampleW    = 10;
  localparam int unsigned SumW       = 14;
  localparam int unsigned CfgW       = 9;
  localparam int unsigned InTdataW   = ((SampleW + 7) / 8) * 8;
  localparam int unsigned OutTdataW  = ((SumW + 7) / 8) * 8;

  // middle window
  localparam int unsigned MidHalf    = 5;
  localparam int unsigned MidSpan    = 10;
  localparam int unsigned SpanW      = $clog2(MidSpan);

  localparam logic [CfgW-1:0] CfgReset = CfgW'(250);

  // read address source
  typedef enum logic [1:0] {
    RdPosM1,
    RdPosM2,
    RdSum
  } rd_sel_e;

  // controller to datapath
  typedef struct packed {
    logic    load;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    wr_shift;
    logic    wr_place;
    logic    sum_init;
    logic    sum_rd;
    logic    finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pos_zero;
    logic pos_one;
    logic gt;
    logic run_done;
    logic sum_last;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/swtm_dp.sv =====
// Datapath: sorted sample store, insertion pointer, fill count, window sum
// and output register. Depends on swtm_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "sorted_window_trimmed_mean_macros.svh"

module swtm_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  swtm_pkg::cmd_t                  cmd_i,
  output swtm_pkg::sts_t                  sts_o,
  input  logic                            cfg_we_i,
  input  logic [swtm_pkg::CfgW-1:0]       cfg_wdata_i,
  input  logic [swtm_pkg::SampleW-1:0]    sample_i,
  input  logic                            channel_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [swtm_pkg::SumW-1:0]       out_sum_o,
  output logic                            out_chan_o
);

  localparam int unsigned AddrW = swtm_pkg::AddrW;
  localparam int unsigned CntW  = swtm_pkg::CntW;

  logic [swtm_pkg::SampleW-1:0] mem [swtm_pkg::MaxSamples];

  logic [swtm_pkg::SampleW-1:0] rdata_q, sample_q;
  logic [AddrW-1:0]             pos_q, idx_q, raddr, start;
  logic [CntW-1:0]              fill_q, n_eff;
  logic [swtm_pkg::SpanW-1:0]   cnt_q;
  logic [swtm_pkg::SumW-1:0]    acc_q, out_sum_q;
  logic [swtm_pkg::CfgW-1:0]    cfg_q;
  logic                         rd_pend_q, run_chan_q, out_valid_q, out_chan_q;

  // effective count, clamped to the window span and the store depth
  always_comb begin
    if (32'(cfg_q) < swtm_pkg::MidSpan) begin
      n_eff = CntW'(swtm_pkg::MidSpan);
    end else if (32'(cfg_q) > swtm_pkg::MaxSamples) begin
      n_eff = CntW'(swtm_pkg::MaxSamples);
    end else begin
      n_eff = CntW'(cfg_q);
    end
  end

  assign start = n_eff[CntW-1:1] - AddrW'(swtm_pkg::MidHalf);

  // read address select
  always_comb begin
    case (cmd_i.rd_sel)
      swtm_pkg::RdPosM1: raddr = pos_q - AddrW'(1);
      swtm_pkg::RdPosM2: raddr = pos_q - AddrW'(2);
      swtm_pkg::RdSum:   raddr = idx_q;
      default:           raddr = pos_q - AddrW'(1);
    endcase
  end

  // store: one write at the insertion pointer, one registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rdata_q <= mem[raddr];
    end
    if (cmd_i.wr_shift) begin
      mem[pos_q] <= rdata_q;
    end else if (cmd_i.wr_place) begin
      mem[pos_q] <= sample_q;
    end
  end

  // payload registers: sample, pointer, window index, accumulator, output sum and tag
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sample_q <= sample_i;
      pos_q    <= fill_q[AddrW-1:0];
    end else if (cmd_i.wr_shift) begin
      pos_q    <= pos_q - AddrW'(1);
    end
    if (cmd_i.sum_init) begin
      idx_q <= start;
      acc_q <= '0;
    end else begin
      if (cmd_i.sum_rd) begin
        idx_q <= idx_q + AddrW'(1);
      end
      if (rd_pend_q) begin
        acc_q <= acc_q + swtm_pkg::SumW'(rdata_q);
      end
    end
    if (cmd_i.finish) begin
      out_sum_q  <= acc_q;
      out_chan_q <= run_chan_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= swtm_pkg::CfgReset;
      fill_q      <= '0;
      run_chan_q  <= 1'b0;
      cnt_q       <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if (cmd_i.load && (fill_q == '0)) begin
        run_chan_q <= channel_i;
      end
      if (cmd_i.finish) begin
        fill_q <= '0;
      end else if (cmd_i.wr_place) begin
        fill_q <= fill_q + CntW'(1);
      end
      if (cmd_i.sum_init) begin
        cnt_q <= '0;
      end else if (cmd_i.sum_rd) begin
        cnt_q <= cnt_q + swtm_pkg::SpanW'(1);
      end
      rd_pend_q <= cmd_i.sum_rd;
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // status to controller
  assign sts_o.pos_zero = (pos_q == '0);
  assign sts_o.pos_one  = (pos_q == AddrW'(1));
  assign sts_o.gt       = (rdata_q > sample_q);
  assign sts_o.run_done = (fill_q >= n_eff);
  assign sts_o.sum_last = (cnt_q == swtm_pkg::SpanW'(swtm_pkg::MidSpan - 1));
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_sum_o   = out_sum_q;
  assign out_chan_o  = out_chan_q;

  // checks
  `SWTM_ASSERT(a_fill_cap, fill_q <= CntW'(swtm_pkg::MaxSamples), "fill count above store depth")
  `SWTM_ASSERT_IMP(a_shift_ok, cmd_i.wr_shift, (pos_q != '0) && (rdata_q > sample_q),
                   "shift without a larger entry below the pointer")
  `SWTM_ASSERT_IMP(a_finish_full, cmd_i.finish, fill_q >= n_eff,
                   "result emitted before the run is full")
  `SWTM_ASSERT(a_place_step, cmd_i.wr_place |=> (fill_q == $past(fill_q) + CntW'(1)),
               "placement did not advance fill count by one")

endmodule

// ===== rtl/swtm_ctrl.sv =====
// Controller: sequences sample accept, insertion walk, window sum and
// result hand-off. Depends on swtm_pkg; drives swtm_dp by command struct.
`timescale 1ns / 1ps

module swtm_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  swtm_pkg::sts_t sts_i,
  output swtm_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK_RD,
    S_WALK_CMP,
    S_CHECK,
    S_SUM,
    S_SUM_WAIT,
    S_OUT
  } state_e;

  state_e state_q, state_d;
  logic   in_ready_q;

  // command decode and next state
  always_comb begin
    cmd_o        = '0;
    cmd_o.rd_sel = swtm_pkg::RdPosM1;
    state_d      = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_q) begin
          cmd_o.load = 1'b1;
          state_d    = S_WALK_RD;
        end
      end
      S_WALK_RD: begin
        if (sts_i.pos_zero) begin
          cmd_o.wr_place = 1'b1;
          state_d        = S_CHECK;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_WALK_CMP;
        end
      end
      S_WALK_CMP: begin
        if (sts_i.gt) begin
          // move entry up one slot, fetch the next one down unless the bottom was reached
          cmd_o.wr_shift = 1'b1;
          if (sts_i.pos_one) begin
            state_d = S_WALK_RD;
          end else begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_sel = swtm_pkg::RdPosM2;
          end
        end else begin
          cmd_o.wr_place = 1'b1;
          state_d        = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.run_done) begin
          cmd_o.sum_init = 1'b1;
          state_d        = S_SUM;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_SUM: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = swtm_pkg::RdSum;
        cmd_o.sum_rd = 1'b1;
        if (sts_i.sum_last) begin
          state_d = S_SUM_WAIT;
        end
      end
      S_SUM_WAIT: begin
        // last read lands in the accumulator
        state_d = S_OUT;
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state and registered ready
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      in_ready_q <= 1'b1;
    end else begin
      state_q    <= state_d;
      in_ready_q <= (state_d == S_IDLE);
    end
  end

  assign in_ready_o = in_ready_q;

endmodule

// ===== rtl/sorted_window_trimmed_mean.sv =====
// Sorted window trimmed mean: top level joining controller and datapath.
// Depends on swtm_pkg, swtm_ctrl and swtm_dp.
//
// Usage: samples enter on the s_axis channel (tdata = 10-bit sample, tuser =
// channel tag). Each beat is inserted into an ascending sorted store by a
// walk that moves one larger entry up per cycle through the store's read
// and write ports. After the walk the sample is placed and the run is
// checked for its end.
// Once sample_count beats (clamped to 10..256) have arrived, the ten middle
// entries are read back one per cycle and summed; the sum goes out on m_axis
// (tdata = mean times ten, tuser = tag of the run's first sample) and a new
// run starts.
// One sample is in work at a time; s_axis_tready is high only while idle.
// A finished result sits in an output register, so a new run may begin
// while it waits; if m_axis is still stalled when the next result is ready
// the block holds in that step until the old beat is taken.
// cfg_we_i/cfg_wdata_i write sample_count; user writes only while idle, not enforced.
// Reset: run is empty, channel tag 0, sample_count 250, no result pending;
// the store needs no clearing since only entries of the current run are read.
`timescale 1ns / 1ps

module sorted_window_trimmed_mean (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [swtm_pkg::CfgW-1:0]         cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [swtm_pkg::InTdataW-1:0]     s_axis_tdata,  // [9:0] sample
  input  logic                              s_axis_tuser,  // [0] channel
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [swtm_pkg::OutTdataW-1:0]    m_axis_tdata,  // [13:0] filtered_tenths
  output logic                              m_axis_tuser   // [0] result_channel
);

  swtm_pkg::cmd_t                cmd;
  swtm_pkg::sts_t                sts;
  logic [swtm_pkg::SumW-1:0]     out_sum;

  swtm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  swtm_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sample_i    (s_axis_tdata[swtm_pkg::SampleW-1:0]),
    .channel_i   (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_sum_o   (out_sum),
    .out_chan_o  (m_axis_tuser)
  );

  // zero-pad the sum to whole bytes
  assign m_axis_tdata = swtm_pkg::OutTdataW'(out_sum);

endmodule

// ===== bench/swtm_mean_checker.sv =====
// Checker for the sorted window trimmed mean block: watches config, sample and
// result beats, keeps its own sorted store and compares every result beat.
// Depends on swtm_pkg for widths and store geometry.
`timescale 1ns / 1ps

module swtm_mean_checker (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     cfg_we_i,
  input  logic [swtm_pkg::CfgW-1:0]                cfg_wdata_i,
  input  logic                                     s_axis_tvalid,
  input  logic                                     s_axis_tready,
  input  logic [swtm_pkg::InTdataW-1:0]            s_axis_tdata,   // [9:0] sample
  input  logic                                     s_axis_tuser,   // [0] channel
  input  logic                                     m_axis_tvalid,
  input  logic                                     m_axis_tready,
  input  logic [swtm_pkg::OutTdataW-1:0]           m_axis_tdata,   // [13:0] filtered_tenths
  input  logic                                     m_axis_tuser,   // [0] result_channel
  output int                                       pending_o,
  output int                                       fail_count_o
);

  typedef struct packed {
    logic [swtm_pkg::SumW-1:0] tenths;
    logic                      channel;
  } mean_beat_t;

  mean_beat_t                   expected_means [$];
  logic [swtm_pkg::SampleW-1:0] sorted_samples [swtm_pkg::MaxSamples];
  int unsigned                  fill_level;
  logic                         run_channel;
  logic [swtm_pkg::CfgW-1:0]    sample_count;

  // register value clamped to the usable window sizes
  function automatic int unsigned window_size(logic [swtm_pkg::CfgW-1:0] cnt);
    int unsigned n;
    n = 32'(cnt);
    if (n < swtm_pkg::MidSpan) n = swtm_pkg::MidSpan;
    if (n > swtm_pkg::MaxSamples) n = swtm_pkg::MaxSamples;
    return n;
  endfunction

  // insertion into the sorted store; at end of run push the middle-ten sum
  task automatic sort_and_take_mean(logic [swtm_pkg::SampleW-1:0] smp, logic ch);
    int unsigned               n;
    int unsigned               pos;
    int unsigned               first;
    logic [swtm_pkg::SumW-1:0] total;
    mean_beat_t                beat;
    n = window_size(sample_count);
    if (fill_level == 0) run_channel = ch;
    if (fill_level < swtm_pkg::MaxSamples) begin
      pos = fill_level;
      while (pos > 0 && sorted_samples[swtm_pkg::AddrW'(pos - 1)] > smp) begin
        sorted_samples[swtm_pkg::AddrW'(pos)] = sorted_samples[swtm_pkg::AddrW'(pos - 1)];
        pos--;
      end
      sorted_samples[swtm_pkg::AddrW'(pos)] = smp;
      fill_level++;
    end
    if (fill_level >= n) begin
      first = n / 2 - swtm_pkg::MidHalf;
      total = '0;
      for (int i = 0; i < swtm_pkg::MidSpan; i++) begin
        total = total + swtm_pkg::SumW'(sorted_samples[swtm_pkg::AddrW'(first + i)]);
      end
      beat.tenths  = total;
      beat.channel = run_channel;
      expected_means.push_back(beat);
      fill_level = 0;
    end
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    fail_count_o++;
  endtask

  // sampled at the edge, before any of this edge's updates land
  always @(posedge clk_i or negedge rst_ni) begin : watch
    mean_beat_t want;
    if (!rst_ni) begin
      fill_level   = 0;
      run_channel  = 1'b0;
      sample_count = swtm_pkg::CfgReset;
      expected_means.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_means.size() == 0) begin
          report_mismatch("result beat with none pending",
                          int'(m_axis_tdata[swtm_pkg::SumW-1:0]), 0);
        end else begin
          want = expected_means.pop_front();
          if (m_axis_tdata[swtm_pkg::SumW-1:0] !== want.tenths)
            report_mismatch("filtered_tenths", int'(m_axis_tdata[swtm_pkg::SumW-1:0]),
                            int'(want.tenths));
          if (m_axis_tuser !== want.channel)
            report_mismatch("result_channel", int'(m_axis_tuser), int'(want.channel));
        end
      end
      if (cfg_we_i) sample_count = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready)
        sort_and_take_mean(s_axis_tdata[swtm_pkg::SampleW-1:0], s_axis_tuser);
    end
    pending_o = expected_means.size();
  end

endmodule

// ===== bench/sorted_window_trimmed_mean_tb.sv =====
// Testbench top for the sorted window trimmed mean block: clock, reset,
// sample stimulus, result back-pressure and the verdict.
// Depends on swtm_pkg, sorted_window_trimmed_mean and swtm_mean_checker.
`timescale 1ns / 1ps

module sorted_window_trimmed_mean_tb;

  localparam int ClkPeriod     = 8;
  localparam int ResetCycles   = 8;
  localparam int WorkCycles    = 320;      // longest insertion walk plus the summing pass
  localparam int HoldCycles    = 3000;
  localparam int CycleLimit    = 2_000_000;
  localparam int TargetItems   = 1050;

  localparam logic [swtm_pkg::SampleW-1:0] EdgeSamples [10] = '{
    10'd1023, 10'd0, 10'd512, 10'd1, 10'd1022, 10'd341, 10'd682, 10'd0, 10'd1023, 10'd5
  };
  localparam int BigCounts [5] = '{250, 255, 256, 257, 511};

  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           cfg_we    = 1'b0;
  logic [swtm_pkg::CfgW-1:0]      cfg_wdata = '0;
  logic                           s_tvalid  = 1'b0;
  logic                           s_tready;
  logic [swtm_pkg::InTdataW-1:0]  s_tdata   = '0;
  logic                           s_tuser   = 1'b0;
  logic                           m_tvalid;
  logic                           m_tready  = 1'b0;
  logic [swtm_pkg::OutTdataW-1:0] m_tdata;
  logic                           m_tuser;

  int pending;
  int fail_count;
  int sent       = 0;
  int burst_left = 0;
  int cycle_cnt  = 0;
  int hold_left  = 0;
  int seg_left   = 0;
  int seg_mode   = 0;
  bit hold_req   = 1'b0;

  always #(ClkPeriod / 2) clk = ~clk;

  sorted_window_trimmed_mean i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser)
  );

  swtm_mean_checker i_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .pending_o     (pending),
    .fail_count_o  (fail_count)
  );

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("Timeout after %0d cycles", cycle_cnt);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side: one long hold on request, otherwise segments of stall patterns
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HoldCycles;
      m_tready <= 1'b0;
    end else begin
      if (seg_left == 0) begin
        seg_mode = $urandom_range(0, 3);
        seg_left = $urandom_range(5, 60);
      end
      seg_left--;
      case (seg_mode)
        1: begin
          m_tready <= 1'($urandom_range(0, 1));
        end
        2: begin
          m_tready <= ($urandom_range(0, 3) == 0);
        end
        default: begin
          m_tready <= 1'b1;
        end
      endcase
    end
  end

  // sample value for the pattern of a phase
  function automatic logic [swtm_pkg::SampleW-1:0] pick_sample(int mode, int idx, int base);
    case (mode)
      1: return swtm_pkg::SampleW'(base);
      2: return swtm_pkg::SampleW'(base + idx * 7);
      3: return swtm_pkg::SampleW'(1023 - idx * 5);
      4: return ($urandom_range(0, 1) == 1) ? 10'd1023 : 10'd0;
      5: return swtm_pkg::SampleW'((base & 1020) | $urandom_range(0, 3));
      default: return swtm_pkg::SampleW'($urandom_range(0, 1023));
    endcase
  endfunction

  // one sample beat; bursts of random length with random gaps between them unless no_gaps is set
  task automatic send_sample(logic [swtm_pkg::SampleW-1:0] smp, logic ch, bit no_gaps);
    int gap;
    if (burst_left == 0) begin
      if (no_gaps) gap = 0;
      else if ($urandom_range(0, 3) == 0) gap = $urandom_range(8, 30);
      else gap = $urandom_range(0, 4);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= swtm_pkg::InTdataW'(smp);
    s_tuser  <= ch;
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  // wait for all results and the last walk to end, then write sample_count
  task automatic settle_and_configure(logic [swtm_pkg::CfgW-1:0] val);
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (WorkCycles) @(posedge clk);
    while (!s_tready) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin : stimulus
    int cnt;
    int eff;
    int n_items;
    int mode;
    int base;
    int phase;
    bit no_gaps;
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // count below ten clamps up; extremes in scrambled order
    settle_and_configure(9'd0);
    for (int i = 0; i < 10; i++) begin
      send_sample(EdgeSamples[i], (i == 0) ? 1'b1 : 1'(i % 2), 1'b1);
    end

    // count above capacity, then lowered mid-run: next sample closes the run
    settle_and_configure(9'd511);
    for (int i = 0; i < 12; i++) begin
      send_sample(swtm_pkg::SampleW'(1000 - 80 * i), (i == 0) ? 1'b0 : 1'b1, 1'b0);
    end
    settle_and_configure(9'd9);
    send_sample(10'd1023, 1'b1, 1'b0);

    // random phases, mostly small windows, now and then a large one
    phase = 0;
    while (sent < TargetItems) begin
      if (phase == 0) cnt = 12;
      else if (phase % 8 == 4) cnt = BigCounts[$urandom_range(0, 4)];
      else cnt = $urandom_range(0, 32);
      eff = (cnt < 10) ? 10 : ((cnt > 256) ? 256 : cnt);
      if (phase == 0) n_items = 60;
      else if (cnt > 32) n_items = eff + $urandom_range(0, 3);
      else n_items = eff * $urandom_range(1, 5) + $urandom_range(0, 7);
      if (n_items > TargetItems - sent) n_items = TargetItems - sent;
      mode = $urandom_range(0, 7);
      if (mode > 5) mode = 0;
      base = $urandom_range(0, 1023);
      if (mode == 1 && $urandom_range(0, 1) == 1) base = ($urandom_range(0, 1) == 1) ? 1023 : 0;
      no_gaps = ($urandom_range(0, 3) == 0);
      settle_and_configure(swtm_pkg::CfgW'(cnt));
      // long result stall while samples keep coming
      if (phase == 0) hold_req = 1'b1;
      for (int k = 0; k < n_items; k++) begin
        send_sample(pick_sample(mode, k, base), 1'($urandom_range(0, 1)), no_gaps);
      end
      phase++;
    end

    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (WorkCycles) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
